// File: rtl/nfi_pkg.sv
// Shared types, constants and helpers of the packet-to-flit injector.
package nfi_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // Field widths of the request and response beats.
   localparam int NODE_W = 6;
   localparam int CHANNEL_W = 3;
   localparam int STAMP_W = 32;
   localparam int LENGTH_W = 7;
   localparam int INDEX_W = 6;
   localparam int KIND_W = 2;

   // Longest packet, in flits; longer offers are clipped to it.
   localparam int MAX_PACKET_FLITS = 64;

   // Flit type codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_HEAD = 2'd0,
      KIND_BODY = 2'd1,
      KIND_TAIL = 2'd2
   } kind_type;

   // One queued packet header as it sits in the packet store.
   typedef struct packed {
      logic [NODE_W-1:0]    source;
      logic [NODE_W-1:0]    destination;
      logic [CHANNEL_W-1:0] channel;
      logic [STAMP_W-1:0]   stamp;
      logic [LENGTH_W-1:0]  length;
   } packet_type;

   localparam int ENTRY_W = $bits(packet_type);

   // Circular queue pointer advance.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

endpackage

// File: rtl/nfi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/noc_packet_to_flit_injector_top.sv
// Top level of the packet-to-flit injector: packet queue and flit sequencer.
//
// Each request beat is one network tick: it may offer a packet header and it
// carries the downstream acknowledge level. The header is appended to a
// 16-entry packet queue (dropped and flagged when the queue is full), and when
// the acknowledge level matches the request level the next flit of the head
// packet is sent and the request level toggles. Every request beat yields
// exactly one response beat. A tick passes the states in order: the beat is
// accepted in ST_IDLE, the store is written at the tail and read at the head
// in ST_READ, and the flit is formed from the registered read data in ST_EMIT
// once the output register is free; the registered read port sets this order.
// A finished response waits in an output register, so the next request beat
// is taken while it is still pending. No clearing pass is needed after reset.
module noc_packet_to_flit_injector_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_offer_valid,
   input  logic [nfi_pkg::NODE_W-1:0]       req_offer_source,
   input  logic [nfi_pkg::NODE_W-1:0]       req_offer_destination,
   input  logic [nfi_pkg::CHANNEL_W-1:0]    req_offer_channel,
   input  logic [nfi_pkg::STAMP_W-1:0]      req_offer_stamp,
   input  logic [nfi_pkg::LENGTH_W-1:0]     req_offer_length,
   input  logic                             req_ack_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_flit_valid,
   output logic [nfi_pkg::NODE_W-1:0]       rsp_flit_source,
   output logic [nfi_pkg::NODE_W-1:0]       rsp_flit_destination,
   output logic [nfi_pkg::CHANNEL_W-1:0]    rsp_flit_channel,
   output logic [nfi_pkg::STAMP_W-1:0]      rsp_flit_stamp,
   output logic [nfi_pkg::INDEX_W-1:0]      rsp_flit_index,
   output logic [nfi_pkg::LENGTH_W-1:0]     rsp_flit_count,
   output logic [nfi_pkg::KIND_W-1:0]       rsp_flit_kind,
   output logic                             rsp_request_level,
   output logic                             rsp_offer_dropped,
   output logic [nfi_pkg::FILL_W-1:0]       rsp_queue_fill
);

   import nfi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // Sequencer and queue control state.
   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [LENGTH_W-1:0] remaining_ff, remaining_in;
   logic                level_ff, level_in;

   // Captured request beat.
   logic                offer_valid_ff;
   logic                ack_ff;
   packet_type          packet_ff, packet_in;

   // Per-tick intermediate results.
   logic                dropped_ff, dropped_in;
   logic                fwd_ff, fwd_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                flit_valid_ff, flit_valid_in;
   packet_type          flit_packet_ff, flit_packet_in;
   logic [INDEX_W-1:0]  flit_index_ff, flit_index_in;
   kind_type            flit_kind_ff, flit_kind_in;
   logic                out_level_ff;
   logic                out_dropped_ff;
   logic [FILL_W-1:0]   out_fill_ff;

   // Packet store ports.
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;

   // Evaluation signals.
   logic                accept;
   logic                push;
   logic                fire;
   logic                out_free;
   packet_type          head_entry;
   logic [LENGTH_W-1:0] rem_start;
   logic [LENGTH_W-1:0] rem_left;
   logic [LENGTH_W-1:0] index_full;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Header normalization: zero length becomes one, long packets are clipped.
   always_comb begin
      packet_in.source = req_offer_source;
      packet_in.destination = req_offer_destination;
      packet_in.channel = req_offer_channel;
      packet_in.stamp = req_offer_stamp;
      if (req_offer_length == '0) begin
         packet_in.length = LENGTH_W'(1);
      end else if (req_offer_length > LENGTH_W'(MAX_PACKET_FLITS)) begin
         packet_in.length = LENGTH_W'(MAX_PACKET_FLITS);
      end else begin
         packet_in.length = req_offer_length;
      end
   end

   // Packet store.
   nfi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (packet_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Head packet, forwarded when it was written into an empty queue this tick.
   assign head_entry = fwd_ff ? packet_ff : packet_type'(ram_rd_data);

   assign push = offer_valid_ff && (fill_ff < FILL_W'(QUEUE_DEPTH));
   assign fire = (ack_ff == level_ff) && (fill_ff != '0);

   // Flit position within the head packet.
   always_comb begin
      if ((remaining_ff == '0) || (remaining_ff > head_entry.length)) begin
         rem_start = head_entry.length;
      end else begin
         rem_start = remaining_ff;
      end
      rem_left = rem_start - LENGTH_W'(1);
      index_full = head_entry.length - rem_start;
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      remaining_in = remaining_ff;
      level_in = level_ff;
      dropped_in = dropped_ff;
      fwd_in = fwd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      flit_valid_in = 1'b0;
      flit_packet_in = '0;
      flit_index_in = '0;
      flit_kind_in = KIND_HEAD;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Push happens before the pop of the same tick.
            ram_wr_en = push;
            ram_rd_en = 1'b1;
            fill_in = fill_ff + FILL_W'(push);
            tail_in = push ? next_slot(tail_ff) : tail_ff;
            dropped_in = offer_valid_ff && !push;
            fwd_in = push && (fill_ff == '0);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (fire) begin
                  flit_valid_in = 1'b1;
                  flit_packet_in = head_entry;
                  flit_index_in = index_full[INDEX_W-1:0];
                  if (rem_start == head_entry.length) begin
                     flit_kind_in = KIND_HEAD;
                  end else if (rem_start == LENGTH_W'(1)) begin
                     flit_kind_in = KIND_TAIL;
                  end else begin
                     flit_kind_in = KIND_BODY;
                  end
                  remaining_in = rem_left;
                  level_in = !level_ff;
                  if (rem_left == '0) begin
                     head_in = next_slot(head_ff);
                     fill_in = fill_ff - FILL_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         remaining_ff <= '0;
         level_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         remaining_ff <= remaining_in;
         level_ff <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: captured beat, tick flags and response fields.
   always_ff @(posedge clock) begin
      if (accept) begin
         offer_valid_ff <= req_offer_valid;
         ack_ff <= req_ack_level;
         packet_ff <= packet_in;
      end
      dropped_ff <= dropped_in;
      fwd_ff <= fwd_in;
      if ((state_ff == ST_EMIT) && out_free) begin
         flit_valid_ff <= flit_valid_in;
         flit_packet_ff <= flit_packet_in;
         flit_index_ff <= flit_index_in;
         flit_kind_ff <= flit_kind_in;
         out_level_ff <= level_in;
         out_dropped_ff <= dropped_ff;
         out_fill_ff <= fill_in;
      end
   end

   // Response beat.
   assign rsp_valid = rsp_valid_ff;
   assign rsp_flit_valid = flit_valid_ff;
   assign rsp_flit_source = flit_packet_ff.source;
   assign rsp_flit_destination = flit_packet_ff.destination;
   assign rsp_flit_channel = flit_packet_ff.channel;
   assign rsp_flit_stamp = flit_packet_ff.stamp;
   assign rsp_flit_index = flit_index_ff;
   assign rsp_flit_count = flit_packet_ff.length;
   assign rsp_flit_kind = flit_kind_ff;
   assign rsp_request_level = out_level_ff;
   assign rsp_offer_dropped = out_dropped_ff;
   assign rsp_queue_fill = out_fill_ff;

   // The queue never holds more packets than it has entries.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("packet queue fill exceeds its depth");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   // A sent flit lies inside its packet.
   a_flit_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flit_valid) |->
         (LENGTH_W'(rsp_flit_index) < rsp_flit_count))
      else $error("flit index beyond packet length");

   // A flit is counted against a started packet that never outgrows the limit.
   a_remaining: assert property (@(posedge clock) disable iff (reset)
      remaining_ff < LENGTH_W'(MAX_PACKET_FLITS))
      else $error("flits remaining out of range");

endmodule
